[src/sumu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted union merge: shared package
// Widths, operation codes, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sumu_pkg;

    // Default number of entries per list.
    localparam int LIST_DEPTH_DEF = 16;

    // Maximum number of results one merge may emit.
    localparam int MAX_RESULTS = 32;

    // Width of one list value.
    localparam int VALUE_W = 32;

    // Width of the emitted-result counter.
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

    // Operation codes on the command port.
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_MERGE  = 2'd2;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_MERGE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_active;
    } status_t;

endpackage

[src/sumu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted union merge: generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sumu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/sumu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted union merge: controller
// Decodes commands while idle and sequences the merge walk, one step a cycle.
// ----------------------------------------------------------------------------
module sumu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         operation,
    input  sumu_pkg::status_t  status,
    output sumu_pkg::cmd_t     cmd,
    output logic               busy
);

    sumu_pkg::state_t state_reg;
    sumu_pkg::state_t state_next;
    logic             accept;

    assign accept = start && (state_reg == sumu_pkg::ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sumu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sumu_pkg::ST_IDLE:
            begin
                if (accept && (operation == sumu_pkg::OP_MERGE))
                begin
                    state_next = sumu_pkg::ST_MERGE;
                end
            end
            sumu_pkg::ST_MERGE:
            begin
                if (!status.walk_active)
                begin
                    state_next = sumu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sumu_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        case (state_reg)
            sumu_pkg::ST_IDLE:
            begin
                cmd.load_a = accept && (operation == sumu_pkg::OP_LOAD_A);
                cmd.load_b = accept && (operation == sumu_pkg::OP_LOAD_B);
            end
            sumu_pkg::ST_MERGE:
            begin
                busy       = 1'b1;
                cmd.step   = status.walk_active;
                cmd.finish = !status.walk_active;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

[src/sumu_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted union merge: datapath
// Holds both lists, their counts and the walk indexes, compares the two
// heads, drops repeats and keeps one result pending so that the last one
// can carry the final mark.
// ----------------------------------------------------------------------------
module sumu_dp #(
    parameter int LIST_DEPTH = sumu_pkg::LIST_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sumu_pkg::cmd_t              cmd,
    input  logic [sumu_pkg::VALUE_W-1:0] item_value,
    output sumu_pkg::status_t           status,
    output logic                        result_valid,
    output logic [sumu_pkg::VALUE_W-1:0] merged_value,
    output logic                        final_value,
    output logic                        union_empty,
    output logic                        overflowed
);

    localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int KW  = sumu_pkg::RES_CNT_W;
    localparam int KW1 = KW + 1;
    localparam int VW  = sumu_pkg::VALUE_W;

    // Counts, indexes and walk state.
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] idx_a_reg, idx_a_next;
    logic [CW-1:0] idx_b_reg, idx_b_next;
    logic          ovf_reg, ovf_next;
    logic [KW-1:0] res_cnt_reg, res_cnt_next;
    logic          have_last_reg, have_last_next;
    logic [VW-1:0] last_reg, last_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [VW-1:0] pend_reg, pend_next;

    // Output word registers.
    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] out_value_reg, out_value_next;
    logic          out_final_reg, out_final_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_ovf_reg, out_ovf_next;

    // Walk signals.
    logic          a_avail, b_avail;
    logic [VW-1:0] head_a, head_b;
    logic          a_lt_b, b_lt_a;
    logic          adv_a, adv_b;
    logic [VW-1:0] pick;
    logic          dup;
    logic          below_max;
    logic          wr_a, wr_b;

    // List storage; reads follow the next index so the head is ready each cycle.
    assign wr_a = cmd.load_a && (cnt_a_reg < CW'(LIST_DEPTH));
    assign wr_b = cmd.load_b && (cnt_b_reg < CW'(LIST_DEPTH));

    sumu_ram #(
        .WIDTH (VW),
        .DEPTH (LIST_DEPTH)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[AW-1:0]),
        .wr_data (item_value),
        .rd_addr (idx_a_next[AW-1:0]),
        .rd_data (head_a)
    );

    sumu_ram #(
        .WIDTH (VW),
        .DEPTH (LIST_DEPTH)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[AW-1:0]),
        .wr_data (item_value),
        .rd_addr (idx_b_next[AW-1:0]),
        .rd_data (head_b)
    );

    // Head selection: smaller head first, both heads when equal.
    always_comb
    begin
        a_avail = idx_a_reg < cnt_a_reg;
        b_avail = idx_b_reg < cnt_b_reg;
        a_lt_b  = $signed(head_a) < $signed(head_b);
        b_lt_a  = $signed(head_b) < $signed(head_a);
        adv_a   = 1'b0;
        adv_b   = 1'b0;
        pick    = head_b;
        if (a_avail && b_avail)
        begin
            if (a_lt_b)
            begin
                adv_a = 1'b1;
                pick  = head_a;
            end
            else if (b_lt_a)
            begin
                adv_b = 1'b1;
            end
            else
            begin
                adv_a = 1'b1;
                adv_b = 1'b1;
                pick  = head_a;
            end
        end
        else if (a_avail)
        begin
            adv_a = 1'b1;
            pick  = head_a;
        end
        else
        begin
            adv_b = 1'b1;
        end
        dup = have_last_reg && (pick == last_reg);
    end

    // The walk goes on while input remains and the result limit is not reached.
    assign below_max = (KW1'({1'b0, res_cnt_reg}) + KW1'(pend_valid_reg)) <
                       KW1'(sumu_pkg::MAX_RESULTS);
    assign status.walk_active = (a_avail || b_avail) && below_max;

    // Next-state logic for loads, the walk and the closing result.
    always_comb
    begin
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        idx_a_next      = idx_a_reg;
        idx_b_next      = idx_b_reg;
        ovf_next        = ovf_reg;
        res_cnt_next    = res_cnt_reg;
        have_last_next  = have_last_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = 1'b0;
        out_value_next  = pend_reg;
        out_final_next  = 1'b0;
        out_empty_next  = 1'b0;
        out_ovf_next    = ovf_reg;

        if (cmd.load_a)
        begin
            if (wr_a)
            begin
                cnt_a_next = cnt_a_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.load_b)
        begin
            if (wr_b)
            begin
                cnt_b_next = cnt_b_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.step)
        begin
            idx_a_next = idx_a_reg + CW'(adv_a);
            idx_b_next = idx_b_reg + CW'(adv_b);
            if (!dup)
            begin
                // A new distinct value releases the one held before it.
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    res_cnt_next   = res_cnt_reg + KW'(1);
                end
                pend_valid_next = 1'b1;
                pend_next       = pick;
                last_next       = pick;
                have_last_next  = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = pend_valid_reg ? pend_reg : '0;
            out_final_next  = 1'b1;
            out_empty_next  = !pend_valid_reg;
            cnt_a_next      = '0;
            cnt_b_next      = '0;
            idx_a_next      = '0;
            idx_b_next      = '0;
            ovf_next        = 1'b0;
            res_cnt_next    = '0;
            have_last_next  = 1'b0;
            pend_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            idx_a_reg      <= '0;
            idx_b_reg      <= '0;
            ovf_reg        <= 1'b0;
            res_cnt_reg    <= '0;
            have_last_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            idx_a_reg      <= idx_a_next;
            idx_b_reg      <= idx_b_next;
            ovf_reg        <= ovf_next;
            res_cnt_reg    <= res_cnt_next;
            have_last_reg  <= have_last_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        pend_reg      <= pend_next;
        out_value_reg <= out_value_next;
        out_final_reg <= out_final_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign result_valid = out_valid_reg;
    assign merged_value = out_value_reg;
    assign final_value  = out_final_reg;
    assign union_empty  = out_empty_reg;
    assign overflowed   = out_ovf_reg;

endmodule

[src/sorted_union_merge_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted union merge unit
// Loads two ascending lists and emits their sorted union without repeats.
//
//   Channel   Handshake               Fields
//   command   start & !busy           operation, item_value
//   result    result_valid (strobe)   merged_value, final_value, union_empty,
//                                     overflowed
//
// A load can be followed by another in the next cycle.
// A merge holds busy through every walk step and one closing step. A
// step takes one head, or one head from each list when they are equal, so a
// merge walks at most 2 * LIST_DEPTH steps. The walk advances one step a
// cycle through the registered RAM reads. Each result word shows for one
// cycle: a value is held until the next distinct value is found and shows in
// the cycle after that step, and the final word shows in the cycle after the
// closing step, when busy is already low. Reset empties both lists; there is
// no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_union_merge_unit #(
    parameter int LIST_DEPTH = sumu_pkg::LIST_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic [sumu_pkg::VALUE_W-1:0] item_value,
    output logic                         result_valid,
    output logic [sumu_pkg::VALUE_W-1:0] merged_value,
    output logic                         final_value,
    output logic                         union_empty,
    output logic                         overflowed
);

    sumu_pkg::cmd_t    cmd;
    sumu_pkg::status_t status;

    // Controller.
    sumu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Datapath.
    sumu_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_value   (item_value),
        .status       (status),
        .result_valid (result_valid),
        .merged_value (merged_value),
        .final_value  (final_value),
        .union_empty  (union_empty),
        .overflowed   (overflowed)
    );

endmodule

[src/sumu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted union merge: port checker
// Watches the top-level ports for the framing of merge results and for busy.
// ----------------------------------------------------------------------------
module sumu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] operation,
    input logic       result_valid,
    input logic       final_value,
    input logic       union_empty
);

    // An empty union is always reported as a single, final word.
    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && union_empty) |-> final_value)
        else $error("empty-union word without final mark");

    // Words before the final one arrive while the merge is still running.
    a_mid_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !final_value) |-> busy)
        else $error("non-final word while idle");

    // The final word of a merge is never directly followed by another word.
    a_gap_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_value) |=> !result_valid)
        else $error("word directly after final word");

    // An accepted merge command raises busy.
    a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == sumu_pkg::OP_MERGE)) |=> busy)
        else $error("merge accepted without busy");

endmodule

bind sorted_union_merge_unit sumu_checker u_sumu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .result_valid (result_valid),
    .final_value  (final_value),
    .union_empty  (union_empty)
);
